/* rtl/core/rtsp_pkg.sv */
package rtsp_pkg;

  // Item kinds on the input channel
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_RENDER = 1'b1;

  // Output modes
  localparam logic [1:0] MODE_MASK  = 2'd0;
  localparam logic [1:0] MODE_STAMP = 2'd1;
  localparam logic [1:0] MODE_GRAY  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_SIDE      = 3'd0;
  localparam logic [2:0] REG_CENTER_X  = 3'd1;
  localparam logic [2:0] REG_CENTER_Y  = 3'd2;
  localparam logic [2:0] REG_COS       = 3'd3;
  localparam logic [2:0] REG_SIN       = 3'd4;
  localparam logic [2:0] REG_INV_ROUND = 3'd5;
  localparam logic [2:0] REG_FLIP      = 3'd6;
  localparam logic [2:0] REG_MODE      = 3'd7;

  // Lightness weights, scale 2^16 (they sum to exactly 2^16)
  localparam logic [15:0] LUMA_R = 16'd19595;
  localparam logic [15:0] LUMA_G = 16'd38470;
  localparam logic [15:0] LUMA_B = 16'd7471;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } texel_t;

  typedef struct packed {
    logic [7:0]         side;
    logic signed [13:0] center_x;
    logic signed [13:0] center_y;
    logic signed [15:0] cos_angle;
    logic signed [15:0] sin_angle;
    logic [15:0]        inv_roundness;
    logic [1:0]         flip;
    logic [1:0]         mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    side:          8'd128,
    center_x:      14'sd1024,
    center_y:      14'sd1024,
    cos_angle:     16'sd16384,
    sin_angle:     16'sd0,
    inv_roundness: 16'd2048,
    flip:          2'd0,
    mode:          MODE_MASK
  };

  // Control that travels with an item through the transform pipeline.
  // hit: for a render, the sample lies inside the tip; for a load, the
  // texel address lies inside the store.
  typedef struct packed {
    logic   render;
    logic   hit;
    texel_t texel;
  } xf_tag_t;

endpackage

/* rtl/core/rtsp_ram.sv */
module rtsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single port, registered read; read data holds while disabled
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/rtsp_xform.sv */
module rtsp_xform #(
  parameter int MAX_SIDE = 128,
  localparam int IdxW = $clog2(MAX_SIDE)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rtsp_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [6:0]         in_pos_x,
  input  logic [6:0]         in_pos_y,
  input  rtsp_pkg::texel_t   in_texel,
  output logic               out_valid,
  input  logic               out_ready,
  output rtsp_pkg::xf_tag_t  out_tag,
  output logic [IdxW-1:0]    out_col,
  output logic [IdxW-1:0]    out_row
);
  import rtsp_pkg::*;

  typedef struct packed {
    xf_tag_t    tag;
    logic [6:0] px;
    logic [6:0] py;
  } xf_item_t;

  localparam int NStg = 6;
  localparam int SideCap = (MAX_SIDE > 255) ? 255 : MAX_SIDE;
  localparam logic [7:0] SideCapV = 8'(SideCap);
  localparam logic [10:0] MaxSideV = 11'(MAX_SIDE);

  logic [NStg:1]   v_r;
  logic [NStg+1:1] en;
  logic [7:0]      side;

  // Stage registers
  xf_item_t           it1_r, it1_nxt, it2_r, it3_r, it4_r, it4_nxt, it5_r, it6_r, it6_nxt;
  logic signed [15:0] dx1_r, dx1_nxt, dy1_r, dy1_nxt;
  logic signed [31:0] p_dc2_r, p_dc2_nxt, p_ds2_r, p_ds2_nxt;
  logic signed [31:0] p_yc2_r, p_yc2_nxt, p_ys2_r, p_ys2_nxt;
  logic signed [31:0] tu3_r, tu3_nxt, vp3_r, vp3_nxt;
  logic signed [47:0] pv4_r, pv4_nxt, tv5_r, tv5_nxt;
  logic [IdxW-1:0]    col4_r, col4_nxt, col5_r, col6_r, col6_nxt, row6_r, row6_nxt;

  // Stage 1 helpers
  logic signed [15:0] cx_ext, cy_ext, posx16, posy16, dx_raw, dy_raw;
  logic               in_render;
  // Stage 4 helpers
  logic signed [48:0] pv_full;
  logic [13:0]        col_full;
  logic               col_hit;
  // Stage 6 helpers
  logic [18:0]        row_full;
  logic               row_hit;
  logic [10:0]        px_w, py_w;

  // Saturate the side to what the store holds
  assign side = (cfg.side > SideCapV) ? SideCapV : cfg.side;

  // Each stage advances when empty or when the next one moves
  always_comb begin
    en[NStg+1] = out_ready;
    for (int k = NStg; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= NStg; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 1: offsets from the dab centre, mirror, bounds of sprite or store
  always_comb begin
    cx_ext = $signed({{2{cfg.center_x[13]}}, cfg.center_x});
    cy_ext = $signed({{2{cfg.center_y[13]}}, cfg.center_y});
    posx16 = $signed({5'b0, in_pos_x, 4'b1000});
    posy16 = $signed({5'b0, in_pos_y, 4'b1000});
    dx_raw = posx16 - cx_ext;
    dy_raw = posy16 - cy_ext;
    dx1_nxt = cfg.flip[0] ? -dx_raw : dx_raw;
    dy1_nxt = cfg.flip[1] ? -dy_raw : dy_raw;
    in_render = (in_func == FUNC_RENDER);
    it1_nxt.tag.render = in_render;
    it1_nxt.tag.texel  = in_texel;
    it1_nxt.px         = in_pos_x;
    it1_nxt.py         = in_pos_y;
    if (in_render) begin
      it1_nxt.tag.hit = ({1'b0, in_pos_x} < side) && ({1'b0, in_pos_y} < side);
    end else begin
      it1_nxt.tag.hit = ({4'b0, in_pos_x} < MaxSideV) && ({4'b0, in_pos_y} < MaxSideV);
    end
  end

  // Stage 2: rotation products
  always_comb begin
    p_dc2_nxt = dx1_r * $signed(cfg.cos_angle);
    p_ds2_nxt = dx1_r * $signed(cfg.sin_angle);
    p_yc2_nxt = dy1_r * $signed(cfg.cos_angle);
    p_ys2_nxt = dy1_r * $signed(cfg.sin_angle);
  end

  // Stage 3: combine into U (with half-side offset) and unstretched V
  always_comb begin
    tu3_nxt = p_dc2_r - p_ys2_r + $signed({7'b0, side, 17'b0});
    vp3_nxt = p_ds2_r + p_yc2_r;
  end

  // Stage 4: stretch V by inverse roundness; truncate U toward zero
  always_comb begin
    pv_full  = vp3_r * $signed({1'b0, cfg.inv_roundness});
    pv4_nxt  = $signed(pv_full[47:0]);
    col_full = tu3_r[31:18];
    if (tu3_r[31]) begin
      // small negative values truncate to column zero
      col_hit  = (&tu3_r[31:18]) && (|tu3_r[17:0]);
      col4_nxt = '0;
    end else begin
      col_hit  = col_full < {6'b0, side};
      col4_nxt = col_full[IdxW-1:0];
    end
    it4_nxt = it3_r;
    if (it3_r.tag.render) begin
      it4_nxt.tag.hit = it3_r.tag.hit && col_hit;
    end
  end

  // Stage 5: add half-side offset to V
  assign tv5_nxt = pv4_r + $signed({12'b0, side, 28'b0});

  // Stage 6: truncate V toward zero, pick the store address
  always_comb begin
    row_full = tv5_r[47:29];
    if (tv5_r[47]) begin
      row_hit = (&tv5_r[47:29]) && (|tv5_r[28:0]);
    end else begin
      row_hit = row_full < {11'b0, side};
    end
    px_w    = {4'b0, it5_r.px};
    py_w    = {4'b0, it5_r.py};
    it6_nxt = it5_r;
    if (it5_r.tag.render) begin
      it6_nxt.tag.hit = it5_r.tag.hit && row_hit;
    end
    if (!it6_nxt.tag.hit) begin
      col6_nxt = '0;
      row6_nxt = '0;
    end else if (it5_r.tag.render) begin
      col6_nxt = col5_r;
      row6_nxt = tv5_r[47] ? '0 : tv5_r[29 +: IdxW];
    end else begin
      col6_nxt = px_w[IdxW-1:0];
      row6_nxt = py_w[IdxW-1:0];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en[1]) begin
      it1_r <= it1_nxt;
      dx1_r <= dx1_nxt;
      dy1_r <= dy1_nxt;
    end
    if (en[2]) begin
      it2_r   <= it1_r;
      p_dc2_r <= p_dc2_nxt;
      p_ds2_r <= p_ds2_nxt;
      p_yc2_r <= p_yc2_nxt;
      p_ys2_r <= p_ys2_nxt;
    end
    if (en[3]) begin
      it3_r <= it2_r;
      tu3_r <= tu3_nxt;
      vp3_r <= vp3_nxt;
    end
    if (en[4]) begin
      it4_r  <= it4_nxt;
      pv4_r  <= pv4_nxt;
      col4_r <= col4_nxt;
    end
    if (en[5]) begin
      it5_r  <= it4_r;
      tv5_r  <= tv5_nxt;
      col5_r <= col4_r;
    end
    if (en[6]) begin
      it6_r  <= it6_nxt;
      col6_r <= col6_nxt;
      row6_r <= row6_nxt;
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v_r[NStg];
  assign out_tag   = it6_r.tag;
  assign out_col   = col6_r;
  assign out_row   = row6_r;

endmodule

/* rtl/core/rtsp_shade.sv */
module rtsp_shade (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       mode,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_hit,
  input  rtsp_pkg::texel_t in_texel,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha
);
  import rtsp_pkg::*;

  logic       out_valid_r;
  logic [7:0] red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt, alpha_r, alpha_nxt;
  logic [24:0] luma_sum;
  logic [7:0]  luma;

  // Weighted lightness
  always_comb begin
    luma_sum = 25'(in_texel.red) * 25'(LUMA_R) + 25'(in_texel.green) * 25'(LUMA_G)
             + 25'(in_texel.blue) * 25'(LUMA_B);
    luma = luma_sum[23:16];
  end

  // Pick the output color; misses and empty texels are transparent black
  always_comb begin
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    alpha_nxt = '0;
    if (in_hit && (in_texel.alpha != 8'd0)) begin
      alpha_nxt = in_texel.alpha;
      unique case (mode)
        MODE_STAMP: begin
          red_nxt   = in_texel.red;
          green_nxt = in_texel.green;
          blue_nxt  = in_texel.blue;
        end
        MODE_GRAY: begin
          red_nxt   = luma;
          green_nxt = luma;
          blue_nxt  = luma;
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !out_valid_r || out_ready;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= alpha_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;
  assign out_alpha = alpha_r;

endmodule

/* rtl/core/rotated_tip_sprite_sampler_unit.sv */
// Channel  | Ports                                        | Beat
// ---------+----------------------------------------------+--------------------------------
// input    | in_valid/in_ready, in_func, in_pos_*, in_tip_* | load texel or render pixel
// result   | out_valid/out_ready, out_red..out_alpha      | one sprite pixel per render
// config   | cfg_we, cfg_idx, cfg_wdata                   | one register write, no wait
//
// One beat is taken per clock while out_ready does not stall the pipeline; a render beat
// crosses six transform stages, the store read and the output register to the result side.
// The store is a single-port RAM; loads write it at the same stage where renders
// read it, so beats see the store in acceptance order. Load beats give no result.
// Reset clears control and configuration only; the store needs no clearing pass.
// A stall on out_ready backs up stage by stage; empty stages still fill.
module rotated_tip_sprite_sampler_unit #(
  parameter int MAX_SIDE = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [6:0]  in_pos_x,
  input  logic [6:0]  in_pos_y,
  input  logic [7:0]  in_tip_red,
  input  logic [7:0]  in_tip_green,
  input  logic [7:0]  in_tip_blue,
  input  logic [7:0]  in_tip_alpha,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha
);
  import rtsp_pkg::*;

  localparam int IdxW  = $clog2(MAX_SIDE);
  localparam int Depth = MAX_SIDE * MAX_SIDE;
  localparam int AddrW = $clog2(Depth);

  cfg_t            cfg_r;
  texel_t          in_texel;
  logic            x_valid, x_ready;
  xf_tag_t         x_tag;
  logic [IdxW-1:0] x_col, x_row;
  logic [AddrW-1:0] ram_addr;
  logic            ram_we;
  logic [31:0]     ram_rdata;
  logic            en_m, m_valid_r, m_hit_r, sh_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SIDE:      cfg_r.side          <= cfg_wdata[7:0];
        REG_CENTER_X:  cfg_r.center_x      <= $signed(cfg_wdata[13:0]);
        REG_CENTER_Y:  cfg_r.center_y      <= $signed(cfg_wdata[13:0]);
        REG_COS:       cfg_r.cos_angle     <= $signed(cfg_wdata);
        REG_SIN:       cfg_r.sin_angle     <= $signed(cfg_wdata);
        REG_INV_ROUND: cfg_r.inv_roundness <= cfg_wdata;
        REG_FLIP:      cfg_r.flip          <= cfg_wdata[1:0];
        REG_MODE:      cfg_r.mode          <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_texel.red   = in_tip_red;
    in_texel.green = in_tip_green;
    in_texel.blue  = in_tip_blue;
    in_texel.alpha = in_tip_alpha;
  end

  rtsp_xform #(
    .MAX_SIDE(MAX_SIDE)
  ) u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .in_pos_x (in_pos_x),
    .in_pos_y (in_pos_y),
    .in_texel (in_texel),
    .out_valid(x_valid),
    .out_ready(x_ready),
    .out_tag  (x_tag),
    .out_col  (x_col),
    .out_row  (x_row)
  );

  // Store access stage: loads write, renders read
  assign en_m     = !m_valid_r || sh_ready;
  assign x_ready  = en_m;
  assign ram_we   = x_valid && !x_tag.render && x_tag.hit;
  assign ram_addr = AddrW'(x_row) * AddrW'(MAX_SIDE) + AddrW'(x_col);

  rtsp_ram #(
    .WIDTH(32),
    .DEPTH(Depth)
  ) u_tip_ram (
    .clk  (clk),
    .en   (en_m),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(x_tag.texel),
    .rdata(ram_rdata)
  );

  // Only render beats move on past the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (en_m) begin
      m_valid_r <= x_valid && x_tag.render;
    end
  end

  always_ff @(posedge clk) begin
    if (en_m) begin
      m_hit_r <= x_tag.hit;
    end
  end

  rtsp_shade u_shade (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (cfg_r.mode),
    .in_valid (m_valid_r),
    .in_ready (sh_ready),
    .in_hit   (m_hit_r),
    .in_texel (texel_t'(ram_rdata)),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_red  (out_red),
    .out_green(out_green),
    .out_blue (out_blue),
    .out_alpha(out_alpha)
  );

`ifndef SYNTHESIS
  // A ready result side never blocks the input side
  a_no_stall_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while result side ready");

  // A new result comes only from a render beat leaving the store stage
  a_result_from_store: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(m_valid_r))
    else $error("result appeared without a store read");

  a_render_into_store: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(m_valid_r) |-> $past(x_valid && x_tag.render))
    else $error("store stage filled without a render beat");

  // Transparent pixels are black
  a_transparent_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_alpha == 8'd0)) |->
      ((out_red == 8'd0) && (out_green == 8'd0) && (out_blue == 8'd0)))
    else $error("transparent pixel carries color");
`endif

endmodule
